@@ hw/rtl/cse_pkg.sv @@
// Shared types, codes and glyph/slot tables for the charlieplexed segment display.
package cse_pkg;

    // Operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_NUMBER = 2'd1,
        OP_LETTER = 2'd2
    } op_t;

    // Glyph indices beyond the decimal digits
    localparam logic [4:0] GLYPH_A    = 5'd10;
    localparam logic [4:0] GLYPH_B    = 5'd11;
    localparam logic [4:0] GLYPH_F    = 5'd12;
    localparam logic [4:0] GLYPH_M    = 5'd13;
    localparam logic [4:0] GLYPH_E    = 5'd14;
    localparam logic [4:0] GLYPH_U    = 5'd15;
    localparam logic [4:0] GLYPH_DASH = 5'd16;

    localparam int MASK_W     = 31;
    localparam int PINS       = 7;
    localparam int TENS_LSB   = 8;
    localparam int UNITS_LSB  = 15;
    localparam int TENTHS_LSB = 22;
    localparam int POINT_LO   = 5;
    localparam int POINT_HI   = 6;
    localparam int MARK_BIT   = 29;
    localparam int SIGN_BIT   = 30;

    localparam logic [4:0]         HOLD_SLOT  = 5'd31;
    localparam logic signed [10:0] NUM_MAX    = 11'sd999;
    localparam logic signed [10:0] NUM_MIN    = -11'sd999;

    typedef struct packed {
        op_t                op;
        logic signed [10:0] number_tenths;
        logic [4:0]         first_glyph;
        logic [4:0]         second_glyph;
    } item_t;

    typedef struct packed {
        logic [PINS-1:0] level;
        logic [PINS-1:0] oe;
    } drive_t;

    function automatic logic [6:0] first_pos_glyph(input logic [4:0] idx);
        logic [6:0] g;
        unique case (idx)
            5'd0:    g = 7'h3F;
            5'd1:    g = 7'h03;
            5'd2:    g = 7'h6D;
            5'd3:    g = 7'h67;
            5'd4:    g = 7'h53;
            5'd5:    g = 7'h76;
            5'd6:    g = 7'h7E;
            5'd7:    g = 7'h23;
            5'd8:    g = 7'h7F;
            5'd9:    g = 7'h77;
            5'd10:   g = 7'h7B;
            5'd11:   g = 7'h5E;
            5'd12:   g = 7'h78;
            5'd13:   g = 7'h3B;
            5'd14:   g = 7'h7C;
            5'd15:   g = 7'h1F;
            5'd16:   g = 7'h40;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

    function automatic logic [6:0] other_pos_glyph(input logic [4:0] idx);
        logic [6:0] g;
        unique case (idx)
            5'd0:    g = 7'h3F;
            5'd1:    g = 7'h06;
            5'd2:    g = 7'h5B;
            5'd3:    g = 7'h4F;
            5'd4:    g = 7'h66;
            5'd5:    g = 7'h6D;
            5'd6:    g = 7'h7D;
            5'd7:    g = 7'h07;
            5'd8:    g = 7'h7F;
            5'd9:    g = 7'h6F;
            5'd10:   g = 7'h77;
            5'd11:   g = 7'h7C;
            5'd12:   g = 7'h71;
            5'd13:   g = 7'h37;
            5'd14:   g = 7'h79;
            5'd15:   g = 7'h3E;
            5'd16:   g = 7'h40;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

    // Pin that carries the mask bit in a slot
    function automatic logic [2:0] slot_high(input logic [4:0] slot);
        logic [2:0] p;
        unique case (slot)
            5'd0:  p = 3'd5;  5'd1:  p = 3'd6;  5'd2:  p = 3'd5;  5'd3:  p = 3'd6;
            5'd4:  p = 3'd5;  5'd5:  p = 3'd3;  5'd6:  p = 3'd5;  5'd7:  p = 3'd4;
            5'd8:  p = 3'd2;  5'd9:  p = 3'd0;  5'd10: p = 3'd0;  5'd11: p = 3'd3;
            5'd12: p = 3'd0;  5'd13: p = 3'd1;  5'd14: p = 3'd0;  5'd15: p = 3'd2;
            5'd16: p = 3'd3;  5'd17: p = 3'd1;  5'd18: p = 3'd5;  5'd19: p = 3'd4;
            5'd20: p = 3'd1;  5'd21: p = 3'd1;  5'd22: p = 3'd3;  5'd23: p = 3'd4;
            5'd24: p = 3'd4;  5'd25: p = 3'd0;  5'd26: p = 3'd2;  5'd27: p = 3'd2;
            5'd28: p = 3'd2;  5'd29: p = 3'd4;  5'd30: p = 3'd3;
            default: p = 3'd0;
        endcase
        return p;
    endfunction

    // Pin pulled low in a slot
    function automatic logic [2:0] slot_low(input logic [4:0] slot);
        logic [2:0] p;
        unique case (slot)
            5'd0:  p = 3'd6;  5'd1:  p = 3'd5;  5'd2:  p = 3'd4;  5'd3:  p = 3'd4;
            5'd4:  p = 3'd2;  5'd5:  p = 3'd2;  5'd6:  p = 3'd3;  5'd7:  p = 3'd6;
            5'd8:  p = 3'd0;  5'd9:  p = 3'd3;  5'd10: p = 3'd4;  5'd11: p = 3'd0;
            5'd12: p = 3'd1;  5'd13: p = 3'd0;  5'd14: p = 3'd2;  5'd15: p = 3'd1;
            5'd16: p = 3'd1;  5'd17: p = 3'd4;  5'd18: p = 3'd1;  5'd19: p = 3'd1;
            5'd20: p = 3'd2;  5'd21: p = 3'd3;  5'd22: p = 3'd4;  5'd23: p = 3'd2;
            5'd24: p = 3'd3;  5'd25: p = 3'd5;  5'd26: p = 3'd5;  5'd27: p = 3'd3;
            5'd28: p = 3'd4;  5'd29: p = 3'd5;  5'd30: p = 3'd5;
            default: p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

@@ hw/rtl/cse_mask.sv @@
// Segment mask register and the number / letter-pair renderer that updates it.
module cse_mask (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  cse_pkg::item_t            item,
    output logic [cse_pkg::MASK_W-1:0] mask
);

    logic [cse_pkg::MASK_W-1:0] mask_reg;
    logic [cse_pkg::MASK_W-1:0] mask_next;
    logic signed [10:0]         v_sat;
    logic                       neg;
    logic [10:0]                v_abs;
    logic [9:0]                 mag;
    logic [3:0]                 tens;
    logic [6:0]                 rem;
    logic [3:0]                 units;
    logic [3:0]                 tenths;
    logic                       pair_ok;
    logic [4:0]                 ga;
    logic [4:0]                 gb;

    // Saturate and split the value into decimal digits by threshold compares
    always_comb
    begin
        if (item.number_tenths > cse_pkg::NUM_MAX)
            v_sat = cse_pkg::NUM_MAX;
        else if (item.number_tenths < cse_pkg::NUM_MIN)
            v_sat = cse_pkg::NUM_MIN;
        else
            v_sat = item.number_tenths;
        neg   = v_sat[10];
        v_abs = neg ? 11'(-v_sat) : 11'(v_sat);
        mag   = v_abs[9:0];

        tens = 4'd0;
        rem  = mag[6:0];
        for (int k = 1; k <= 9; k++)
        begin
            if (mag >= 10'(k * 100))
            begin
                tens = 4'(k);
                rem  = 7'(mag - 10'(k * 100));
            end
        end

        units  = 4'd0;
        tenths = rem[3:0];
        for (int k = 1; k <= 9; k++)
        begin
            if (rem >= 7'(k * 10))
            begin
                units  = 4'(k);
                tenths = 4'(rem - 7'(k * 10));
            end
        end
    end

    always_comb
    begin
        ga = item.first_glyph;
        gb = item.second_glyph;
        pair_ok = (ga == cse_pkg::GLYPH_A && gb == cse_pkg::GLYPH_U) ||
                  (ga == cse_pkg::GLYPH_A && gb == cse_pkg::GLYPH_B) ||
                  (ga == cse_pkg::GLYPH_F && gb == cse_pkg::GLYPH_E) ||
                  (ga == cse_pkg::GLYPH_A && gb == cse_pkg::GLYPH_F) ||
                  (ga == cse_pkg::GLYPH_M && gb == cse_pkg::GLYPH_A) ||
                  (ga == cse_pkg::GLYPH_DASH && gb == cse_pkg::GLYPH_DASH);

        mask_next = mask_reg;
        if (fire && item.op == cse_pkg::OP_NUMBER)
        begin
            mask_next[cse_pkg::SIGN_BIT]        = neg;
            mask_next[cse_pkg::TENS_LSB +: 7]   = cse_pkg::first_pos_glyph({1'b0, tens});
            mask_next[cse_pkg::UNITS_LSB +: 7]  = cse_pkg::other_pos_glyph({1'b0, units});
            mask_next[cse_pkg::TENTHS_LSB +: 7] = cse_pkg::other_pos_glyph({1'b0, tenths});
            mask_next[cse_pkg::MARK_BIT]        = 1'b1;
            mask_next[cse_pkg::POINT_HI]        = 1'b1;
            mask_next[cse_pkg::POINT_LO]        = 1'b1;
        end
        else if (fire && item.op == cse_pkg::OP_LETTER)
        begin
            if (pair_ok)
            begin
                mask_next[cse_pkg::TENS_LSB +: 7]  = cse_pkg::first_pos_glyph(ga);
                mask_next[cse_pkg::UNITS_LSB +: 7] = cse_pkg::other_pos_glyph(gb);
            end
            mask_next[cse_pkg::SIGN_BIT:cse_pkg::TENTHS_LSB] = '0;
            mask_next[cse_pkg::POINT_HI]                     = 1'b0;
            mask_next[cse_pkg::POINT_LO]                     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    assign mask = mask_reg;

    // A letter pair always leaves the third digit, sign and points dark
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.op == cse_pkg::OP_LETTER) |=>
            (mask_reg[cse_pkg::SIGN_BIT:cse_pkg::TENTHS_LSB] == '0) &&
            !mask_reg[cse_pkg::POINT_HI] && !mask_reg[cse_pkg::POINT_LO])
        else $error("letter pair left lower digit or marks lit");

    // Scan ticks never touch the mask
    assert property (@(posedge clk) disable iff (!rst_n)
        (!fire || item.op == cse_pkg::OP_TICK) |=> $stable(mask_reg))
        else $error("mask changed without a render word");

endmodule

@@ hw/rtl/cse_scan.sv @@
// Slot counter and held pin drive for scanning the mask across the seven pins.
module cse_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tick,
    input  logic [cse_pkg::MASK_W-1:0] mask,
    output cse_pkg::drive_t            drive_next,
    output logic [4:0]                 slot_next
);

    logic [4:0]      slot_reg;
    cse_pkg::drive_t held_reg;
    logic [2:0]      hi_pin;
    logic [2:0]      lo_pin;
    logic [31:0]     mask_ext;

    always_comb
    begin
        slot_next = slot_reg + 5'd1;
        hi_pin    = cse_pkg::slot_high(slot_next);
        lo_pin    = cse_pkg::slot_low(slot_next);
        mask_ext  = {1'b0, mask};
        if (slot_next == cse_pkg::HOLD_SLOT)
        begin
            drive_next = held_reg;
        end
        else
        begin
            drive_next.oe    = (7'b1 << hi_pin) | (7'b1 << lo_pin);
            drive_next.level = mask_ext[slot_next] ? (7'b1 << hi_pin) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= '0;
            held_reg.oe    <= '1;
            held_reg.level <= '0;
        end
        else if (tick)
        begin
            slot_reg <= slot_next;
            held_reg <= drive_next;
        end
    end

    // Scan slots drive exactly two pins and only the high pin may go high
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick && slot_next != cse_pkg::HOLD_SLOT) |->
            ($countones(drive_next.oe) == 2) && ((drive_next.level & ~drive_next.oe) == '0))
        else $error("scan slot drive malformed");

    // Hold slot repeats the previous drive
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick && slot_next == cse_pkg::HOLD_SLOT) |-> (drive_next == held_reg))
        else $error("hold slot changed the drive");

    // The counter moves on ticks only
    assert property (@(posedge clk) disable iff (!rst_n)
        !tick |=> $stable(slot_reg))
        else $error("slot counter moved without a tick");

endmodule

@@ hw/rtl/charlieplex_segment_display_top.sv @@
// Top level of the charlieplexed three-digit seven-segment display driver.
//
// Takes one command word per cycle unless a held tick stalls the input: a scan
// tick, a signed number in tenths (saturated to +/-99.9) or a letter pair, and
// keeps a 31-bit segment mask that it scans over seven charlieplexed pins a..g.
// Each word is held in an input register; from there a single pass of table
// lookups and digit compares updates the mask or the scan state. Only a scan
// tick yields an output word: the pin enables, the pin levels and the slot
// reached, 0..31, where slot 31 repeats the previous drive. Throughput is one
// word per clock while no tick waits for the output. With a free output, a
// tick passes through the input register and then the output register before
// output valid rises. The output and input registers decouple the two sides:
// while an output word waits, one more word is taken in, and number and letter
// words keep draining; a tick waits in the input register for the output to
// free up.
// Reset clears the mask, the slot and any pending output word.
module charlieplex_segment_display_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [10:0] number_tenths (signed), [15:11] first_glyph, [20:16] second_glyph
    input  logic [23:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] pin_output_enable, [13:7] pin_level, [18:14] scan_slot
    output logic [23:0] m_axis_tdata
);

    logic            in_valid_reg;
    cse_pkg::item_t  in_item_reg;
    logic            out_valid_reg;
    logic [23:0]     out_data_reg;

    logic            in_is_tick;
    logic            out_free;
    logic            in_fire;
    logic            tick_fire;
    logic            s_fire;

    logic [cse_pkg::MASK_W-1:0] mask;
    cse_pkg::drive_t            drive_next;
    logic [4:0]                 slot_next;

    // Retire the held word when it needs no output space or the output frees up
    assign in_is_tick    = (in_item_reg.op == cse_pkg::OP_TICK);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_fire       = in_valid_reg && (!in_is_tick || out_free);
    assign tick_fire     = in_fire && in_is_tick;
    assign s_axis_tready = !in_valid_reg || in_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Capture the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg.op            <= cse_pkg::op_t'(s_axis_tuser);
            in_item_reg.number_tenths <= s_axis_tdata[10:0];
            in_item_reg.first_glyph   <= s_axis_tdata[15:11];
            in_item_reg.second_glyph  <= s_axis_tdata[20:16];
        end
    end

    cse_mask u_mask (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (in_fire),
        .item  (in_item_reg),
        .mask  (mask)
    );

    cse_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick_fire),
        .mask       (mask),
        .drive_next (drive_next),
        .slot_next  (slot_next)
    );

    // Output register: load on a tick, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (tick_fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
            out_data_reg <= {5'b0, slot_next, drive_next.level, drive_next.oe};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A tick never overwrites a word that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |-> (!out_valid_reg || m_axis_tready))
        else $error("tick overwrote a pending output word");

    // Render words produce no output word
    assert property (@(posedge clk) disable iff (!rst_n)
        (!tick_fire && (!out_valid_reg || m_axis_tready)) |=> !out_valid_reg)
        else $error("output word appeared without a tick");

endmodule

@@ sim/tb_charlieplex_segment_display_top.sv @@
// Self-checking testbench for the charlieplexed segment display driver.
`timescale 1ns / 100ps

module tb_charlieplex_segment_display_top;

    localparam int CLK_HALF     = 4;
    localparam int LONG_STALL   = 200;
    localparam int RANDOM_ITEMS = 1100;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int RUN_LIMIT_NS = 4000000;

    // tuser code that the block drops without any effect
    localparam logic [1:0] OP_NOP = 2'd3;

    // Segment patterns per glyph index, bit i lights segment i of the position
    localparam logic [0:16][6:0] TENS_PATTERN = {
        7'h3F, 7'h03, 7'h6D, 7'h67, 7'h53, 7'h76, 7'h7E, 7'h23, 7'h7F, 7'h77,
        7'h7B, 7'h5E, 7'h78, 7'h3B, 7'h7C, 7'h1F, 7'h40
    };
    localparam logic [0:16][6:0] LOWER_PATTERN = {
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
        7'h77, 7'h7C, 7'h71, 7'h37, 7'h79, 7'h3E, 7'h40
    };

    // Charlieplex wiring per slot: pin that carries the mask bit, pin held low
    localparam logic [0:30][2:0] SLOT_HIGH_PIN = {
        3'd5, 3'd6, 3'd5, 3'd6, 3'd5, 3'd3, 3'd5, 3'd4, 3'd2, 3'd0, 3'd0, 3'd3,
        3'd0, 3'd1, 3'd0, 3'd2, 3'd3, 3'd1, 3'd5, 3'd4, 3'd1, 3'd1, 3'd3, 3'd4,
        3'd4, 3'd0, 3'd2, 3'd2, 3'd2, 3'd4, 3'd3
    };
    localparam logic [0:30][2:0] SLOT_LOW_PIN = {
        3'd6, 3'd5, 3'd4, 3'd4, 3'd2, 3'd2, 3'd3, 3'd6, 3'd0, 3'd3, 3'd4, 3'd0,
        3'd1, 3'd0, 3'd2, 3'd1, 3'd1, 3'd4, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd2,
        3'd3, 3'd5, 3'd5, 3'd3, 3'd4, 3'd5, 3'd5
    };

    typedef struct packed {
        logic [6:0] oe;
        logic [6:0] level;
        logic [4:0] slot;
    } pin_drive_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    // Mirror of the display state
    logic [30:0] seg_mask;
    logic [4:0]  scan_slot;
    logic [6:0]  held_oe;
    logic [6:0]  held_level;

    pin_drive_t  pending_drive_q[$];
    int          error_count;
    int          burst_left;
    bit          gaps_on;
    bit          stall_request;

    charlieplex_segment_display_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Hard stop in case the block hangs on either handshake
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[charlieplex_segment_display_top] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
        error_count++;
    endtask

    // Render a signed value in tenths: saturate, split into digits, set marks
    task automatic render_number(input logic signed [10:0] raw);
        int value;
        int mag;
        value = raw;
        if (value > cse_pkg::NUM_MAX)
            value = cse_pkg::NUM_MAX;
        if (value < cse_pkg::NUM_MIN)
            value = cse_pkg::NUM_MIN;
        mag = (value < 0) ? -value : value;
        seg_mask[cse_pkg::SIGN_BIT] = (value < 0);
        seg_mask[cse_pkg::TENS_LSB +: 7]   = TENS_PATTERN[mag / 100];
        seg_mask[cse_pkg::UNITS_LSB +: 7]  = LOWER_PATTERN[(mag / 10) % 10];
        seg_mask[cse_pkg::TENTHS_LSB +: 7] = LOWER_PATTERN[mag % 10];
        seg_mask[cse_pkg::MARK_BIT] = 1'b1;
        seg_mask[cse_pkg::POINT_HI] = 1'b1;
        seg_mask[cse_pkg::POINT_LO] = 1'b1;
    endtask

    // Only six letter pairs reach the digits; every letter word clears the rest
    task automatic render_letters(input logic [4:0] first, input logic [4:0] second);
        bit known;
        known = (first == cse_pkg::GLYPH_A && second == cse_pkg::GLYPH_U) ||
                (first == cse_pkg::GLYPH_A && second == cse_pkg::GLYPH_B) ||
                (first == cse_pkg::GLYPH_F && second == cse_pkg::GLYPH_E) ||
                (first == cse_pkg::GLYPH_A && second == cse_pkg::GLYPH_F) ||
                (first == cse_pkg::GLYPH_M && second == cse_pkg::GLYPH_A) ||
                (first == cse_pkg::GLYPH_DASH && second == cse_pkg::GLYPH_DASH);
        if (known)
        begin
            seg_mask[cse_pkg::TENS_LSB +: 7]  = TENS_PATTERN[first];
            seg_mask[cse_pkg::UNITS_LSB +: 7] = LOWER_PATTERN[second];
        end
        seg_mask[cse_pkg::SIGN_BIT:cse_pkg::TENTHS_LSB] = '0;
        seg_mask[cse_pkg::POINT_HI] = 1'b0;
        seg_mask[cse_pkg::POINT_LO] = 1'b0;
    endtask

    // Advance the scan one slot and queue the pin drive it must produce
    task automatic advance_scan();
        logic [2:0] hi;
        logic [2:0] lo;
        scan_slot = scan_slot + 5'd1;
        if (scan_slot != cse_pkg::HOLD_SLOT)
        begin
            hi = SLOT_HIGH_PIN[scan_slot];
            lo = SLOT_LOW_PIN[scan_slot];
            held_oe = '0;
            held_oe[hi] = 1'b1;
            held_oe[lo] = 1'b1;
            held_level = '0;
            held_level[hi] = seg_mask[scan_slot];
        end
        pending_drive_q.push_back('{oe: held_oe, level: held_level, slot: scan_slot});
    endtask

    task automatic predict_display(input logic [1:0] op, input logic signed [10:0] num,
                                   input logic [4:0] first, input logic [4:0] second);
        case (op)
            cse_pkg::OP_TICK:   advance_scan();
            cse_pkg::OP_NUMBER: render_number(num);
            cse_pkg::OP_LETTER: render_letters(first, second);
            default:   ;
        endcase
    endtask

    // Offer one word until it is taken; close the burst with a random gap
    task automatic send_word(input logic [1:0] op, input logic signed [10:0] num,
                             input logic [4:0] first, input logic [4:0] second);
        bit taken;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, second, first, num};
        taken = 1'b0;
        while (!taken)
        begin
            // tready is settled mid-cycle; a high value means the next edge takes the word
            @(negedge clk);
            taken = s_axis_tready;
            if (taken)
                predict_display(op, num, first, second);
            @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = 0;
            if (gaps_on && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_tick();
        send_word(cse_pkg::OP_TICK, 11'($urandom), 5'($urandom), 5'($urandom));
    endtask

    // Drop valid and hold until every queued drive has come out
    task automatic wait_drain();
        int waited;
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_drive_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_drive_q.size() != 0)
            report_mismatch("words never delivered", 0, pending_drive_q.size());
        repeat (8) @(posedge clk);
    endtask

    // Receiver: sample mid-cycle, so the word counted is the one the next edge takes
    always @(negedge clk)
    begin
        pin_drive_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_drive_q.size() == 0)
                report_mismatch("word with nothing pending", m_axis_tdata, 0);
            else
            begin
                want = pending_drive_q.pop_front();
                if (m_axis_tdata[6:0] !== want.oe)
                    report_mismatch("pin_output_enable", m_axis_tdata[6:0], want.oe);
                if (m_axis_tdata[13:7] !== want.level)
                    report_mismatch("pin_level", m_axis_tdata[13:7], want.level);
                if (m_axis_tdata[18:14] !== want.slot)
                    report_mismatch("scan_slot", m_axis_tdata[18:14], want.slot);
            end
        end
    end

    // Receiver stall pattern: switch between modes after a random run;
    // a stall request forces a long hold-off counted here
    initial
    begin
        int mode;
        int mode_left;
        int stall_count;
        logic [7:0] rx_pattern;
        m_axis_tready = 1'b0;
        mode = 0;
        mode_left = 0;
        stall_count = 0;
        rx_pattern = 8'hFF;
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                m_axis_tready <= 1'b0;
                stall_count++;
                if (stall_count >= LONG_STALL)
                begin
                    stall_request = 1'b0;
                    stall_count = 0;
                end
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                    rx_pattern = 8'($urandom) | 8'h01;
                end
                mode_left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default:
                    begin
                        m_axis_tready <= rx_pattern[0];
                        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                    end
                endcase
            end
        end
    end

    // Saturation at both ends, zero, negative sign
    task automatic test_number_extremes();
        send_word(cse_pkg::OP_NUMBER, 11'sd999, 5'd0, 5'd0);
        send_tick();
        send_word(cse_pkg::OP_NUMBER, -11'sd999, 5'd31, 5'd31);
        send_tick();
        send_word(cse_pkg::OP_NUMBER, 11'sd1023, 5'd0, 5'd0);
        send_word(cse_pkg::OP_NUMBER, 11'h400, 5'd0, 5'd0);
        send_tick();
        send_word(cse_pkg::OP_NUMBER, 11'sd0, 5'd0, 5'd0);
        send_word(cse_pkg::OP_NUMBER, -11'sd7, 5'd0, 5'd0);
        send_tick();
    endtask

    // All six known pairs, plus unknown pairs that must leave the digits alone
    task automatic test_letter_pairs();
        send_word(cse_pkg::OP_LETTER, 11'sd0, cse_pkg::GLYPH_A, cse_pkg::GLYPH_U);
        send_word(cse_pkg::OP_LETTER, 11'sd0, cse_pkg::GLYPH_A, cse_pkg::GLYPH_B);
        send_tick();
        send_word(cse_pkg::OP_LETTER, 11'sd0, cse_pkg::GLYPH_F, cse_pkg::GLYPH_E);
        send_word(cse_pkg::OP_LETTER, 11'sd0, cse_pkg::GLYPH_A, cse_pkg::GLYPH_F);
        send_word(cse_pkg::OP_LETTER, 11'sd0, cse_pkg::GLYPH_M, cse_pkg::GLYPH_A);
        send_tick();
        send_word(cse_pkg::OP_LETTER, 11'sd0, cse_pkg::GLYPH_DASH, cse_pkg::GLYPH_DASH);
        send_word(cse_pkg::OP_LETTER, 11'sd0, cse_pkg::GLYPH_A, cse_pkg::GLYPH_A);
        send_word(cse_pkg::OP_LETTER, 11'sd0, 5'd31, 5'd31);
        send_tick();
    endtask

    task automatic test_ignored_operation();
        send_word(OP_NOP, 11'h7FF, 5'd31, 5'd31);
        send_tick();
        wait_drain();
    endtask

    // Hold the receiver off while words keep coming, so the block backs up
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        burst_left = 0;
        stall_request = 1'b1;
        repeat (6) send_tick();
        send_word(cse_pkg::OP_NUMBER, 11'sd123, 5'd0, 5'd0);
        repeat (10) send_tick();
        send_word(cse_pkg::OP_LETTER, 11'sd0, cse_pkg::GLYPH_F, cse_pkg::GLYPH_E);
        repeat (10) send_tick();
        gaps_on = 1'b1;
        wait_drain();
    endtask

    // Random display updates and dropped words, each followed by a random run of scan ticks
    task automatic test_random_traffic();
        int sent;
        int pick;
        int run;
        logic signed [10:0] num;
        logic [4:0] first;
        logic [4:0] second;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            num = 11'($urandom);
            first = 5'($urandom);
            second = 5'($urandom);
            if (pick < 50)
            begin
                case ($urandom_range(0, 3))
                    0: ;
                    1, 2: num = 11'($urandom_range(0, 1998) - 999);
                    default:
                    begin
                        case ($urandom_range(0, 5))
                            0: num = cse_pkg::NUM_MAX;
                            1: num = cse_pkg::NUM_MIN;
                            2: num = 11'sd1000;
                            3: num = -11'sd1000;
                            4: num = 11'sd1023;
                            default: num = 11'h400;
                        endcase
                    end
                endcase
                send_word(cse_pkg::OP_NUMBER, num, first, second);
            end
            else if (pick < 90)
            begin
                if ($urandom_range(0, 2) != 0)
                begin
                    case ($urandom_range(0, 5))
                        0: begin first = cse_pkg::GLYPH_A; second = cse_pkg::GLYPH_U; end
                        1: begin first = cse_pkg::GLYPH_A; second = cse_pkg::GLYPH_B; end
                        2: begin first = cse_pkg::GLYPH_F; second = cse_pkg::GLYPH_E; end
                        3: begin first = cse_pkg::GLYPH_A; second = cse_pkg::GLYPH_F; end
                        4: begin first = cse_pkg::GLYPH_M; second = cse_pkg::GLYPH_A; end
                        default:
                        begin
                            first = cse_pkg::GLYPH_DASH;
                            second = cse_pkg::GLYPH_DASH;
                        end
                    endcase
                end
                send_word(cse_pkg::OP_LETTER, num, first, second);
            end
            else
                send_word(OP_NOP, num, first, second);
            sent++;
            run = ($urandom_range(0, 2) == 0) ? $urandom_range(32, 40) : $urandom_range(0, 24);
            repeat (run)
            begin
                send_tick();
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = cse_pkg::OP_TICK;
        error_count = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        stall_request = 1'b0;
        seg_mask = '0;
        scan_slot = '0;
        held_oe = 7'h7F;
        held_level = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_number_extremes();
        test_letter_pairs();
        test_ignored_operation();
        test_output_backpressure();
        test_random_traffic();
        wait_drain();

        if (error_count == 0)
            $display("[charlieplex_segment_display_top] OK");
        else
            $display("[charlieplex_segment_display_top] ERROR");
        $finish;
    end

endmodule

@@ charlieplex_segment_display_top.f @@
hw/rtl/cse_pkg.sv
hw/rtl/cse_mask.sv
hw/rtl/cse_scan.sv
hw/rtl/charlieplex_segment_display_top.sv
sim/tb_charlieplex_segment_display_top.sv
